### sv/unordered_key_value_table_unit_assert.svh
// assertion macros used by the table RTL
`ifndef UNORDERED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define UNORDERED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UKVT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ukvt assertion failed");

// next-cycle implication, checked outside reset
`define UKVT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ukvt assertion failed");

`endif

### sv/ukvt_pkg.sv
package ukvt_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ENTRY_COUNT_W = 5;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam data_t MISS_MARK = -32'sd999;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		logic occupied;
		logic ins_here;
		logic do_ins;
		logic do_del;
	} cell_ctl_t;

endpackage

### sv/ukvt_if.sv
interface ukvt_req_if;
	logic                valid;
	logic                ready;
	ukvt_pkg::action_t   action;
	ukvt_pkg::data_t     key;
	ukvt_pkg::data_t     entry_value;

	modport source(output valid, action, key, entry_value, input ready);
	modport sink(input valid, action, key, entry_value, output ready);
endinterface

interface ukvt_rsp_if;
	logic                                   valid;
	logic                                   ready;
	ukvt_pkg::data_t                        read_value;
	logic                                   found;
	logic                                   dropped;
	logic [ukvt_pkg::ENTRY_COUNT_W-1:0]     entry_count;
	logic                                   is_empty;
	logic                                   is_full;

	modport source(output valid, read_value, found, dropped, entry_count, is_empty, is_full,
		input ready);
	modport sink(input valid, read_value, found, dropped, entry_count, is_empty, is_full,
		output ready);
endinterface

### sv/ukvt_cell.sv
module ukvt_cell (
	input  logic                  clk,
	input  ukvt_pkg::cell_ctl_t   ctl,
	input  ukvt_pkg::data_t       key,
	input  ukvt_pkg::data_t       entry_value,
	input  ukvt_pkg::data_t       up_key,
	input  ukvt_pkg::data_t       up_value,
	input  logic                  seen_in,
	input  ukvt_pkg::data_t       rd_in,
	output ukvt_pkg::data_t       cell_key,
	output ukvt_pkg::data_t       cell_value,
	output logic                  seen_out,
	output ukvt_pkg::data_t       rd_out
);

	ukvt_pkg::data_t key_q;
	ukvt_pkg::data_t value_q;
	logic            match;

	assign match      = ctl.occupied && (key_q == key);
	assign seen_out   = seen_in | match;
	assign rd_out     = rd_in | (match ? value_q : '0);
	assign cell_key   = key_q;
	assign cell_value = value_q;

	// insert lands at the fill point; delete pulls every cell at or above the hit down
	always_ff @(posedge clk) begin
		if (ctl.do_ins && ctl.ins_here) begin
			key_q   <= key;
			value_q <= entry_value;
		end else if (ctl.do_del && seen_out) begin
			key_q   <= up_key;
			value_q <= up_value;
		end
	end

endmodule

### sv/unordered_key_value_table_unit.sv
// channel | dir | handshake   | payload
// req     | in  | valid/ready | action, key, entry_value
// rsp     | out | valid/ready | read_value, found, dropped, entry_count, is_empty, is_full
//
// One item per cycle: a new item is taken whenever the result register is empty or
// being drained, so back-pressure on rsp stalls req in the same cycle.
// The key compare runs in all cells at once; the hit flag and read data ripple
// along the cell row, and the delete shift moves every cell at or above the hit.
// The result is registered and appears in the cycle after the item is accepted.
// Reset clears the fill count and the result valid flag; cell contents are
// undefined, and cells at or above the fill count are never read.
`include "unordered_key_value_table_unit_assert.svh"

module unordered_key_value_table_unit (
	input  logic       clk,
	input  logic       arst_n,
	ukvt_req_if.sink   req,
	ukvt_rsp_if.source rsp
);

	localparam int CAP = ukvt_pkg::CAPACITY;

	ukvt_pkg::cnt_t   count_q;
	ukvt_pkg::cnt_t   cnt_next;
	logic             rsp_valid_q;
	ukvt_pkg::data_t  read_value_q;
	logic             found_q;
	logic             dropped_q;
	logic [ukvt_pkg::ENTRY_COUNT_W-1:0] entry_count_q;
	logic             is_empty_q;
	logic             is_full_q;

	logic             accept;
	logic             found;
	logic             do_ins;
	logic             do_del;
	logic             drop;
	ukvt_pkg::data_t  read_value;

	logic             seen [CAP+1];
	ukvt_pkg::data_t  rd [CAP+1];
	ukvt_pkg::data_t  cell_key [CAP];
	ukvt_pkg::data_t  cell_value [CAP];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign seen[0] = 1'b0;
	assign rd[0]   = '0;
	assign found   = seen[CAP];

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		localparam int UP = (i + 1 < CAP) ? i + 1 : i;
		localparam ukvt_pkg::cnt_t IDX = ukvt_pkg::CNT_W'(i);
		ukvt_pkg::cell_ctl_t ctl;

		assign ctl.occupied = IDX < count_q;
		assign ctl.ins_here = IDX == count_q;
		assign ctl.do_ins   = do_ins;
		assign ctl.do_del   = do_del;

		ukvt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.key         (req.key),
			.entry_value (req.entry_value),
			.up_key      (cell_key[UP]),
			.up_value    (cell_value[UP]),
			.seen_in     (seen[i]),
			.rd_in       (rd[i]),
			.cell_key    (cell_key[i]),
			.cell_value  (cell_value[i]),
			.seen_out    (seen[i+1]),
			.rd_out      (rd[i+1])
		);
	end

	always_comb begin
		do_ins     = 1'b0;
		do_del     = 1'b0;
		drop       = 1'b0;
		read_value = ukvt_pkg::MISS_MARK;
		cnt_next   = count_q;
		unique case (req.action)
			ukvt_pkg::ACT_LOOKUP: begin
				if (found)
					read_value = rd[CAP];
			end
			ukvt_pkg::ACT_INSERT: begin
				if (!found) begin
					if (count_q < ukvt_pkg::CNT_W'(CAP)) begin
						do_ins   = accept;
						cnt_next = count_q + ukvt_pkg::CNT_W'(1);
					end else begin
						drop = 1'b1;
					end
				end
			end
			ukvt_pkg::ACT_DELETE: begin
				if (found) begin
					do_del   = accept;
					cnt_next = count_q - ukvt_pkg::CNT_W'(1);
				end
			end
			ukvt_pkg::ACT_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept)
				count_q <= cnt_next;
			if (req.ready)
				rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= read_value;
			found_q       <= found;
			dropped_q     <= drop;
			entry_count_q <= ukvt_pkg::ENTRY_COUNT_W'(cnt_next);
			is_empty_q    <= cnt_next == '0;
			is_full_q     <= cnt_next == ukvt_pkg::CNT_W'(CAP);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.found       = found_q;
	assign rsp.dropped     = dropped_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.is_empty    = is_empty_q;
	assign rsp.is_full     = is_full_q;

	`UKVT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= ukvt_pkg::CNT_W'(CAP))
	`UKVT_ASSERT_NEXT(a_ins_grows, do_ins, count_q == $past(count_q) + ukvt_pkg::CNT_W'(1))
	`UKVT_ASSERT_NEXT(a_del_shrinks, do_del, count_q == $past(count_q) - ukvt_pkg::CNT_W'(1))
	`UKVT_ASSERT_NEXT(a_result_follows, accept, rsp_valid_q)
	`UKVT_ASSERT_NOW(a_drop_when_full, rsp_valid_q && dropped_q, is_full_q && !found_q)

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int KEY_POOL_N = 24;
	localparam int REPORT_W = ukvt_pkg::DATA_W + 1;

	typedef struct {
		ukvt_pkg::data_t                    read_value;
		logic                               found;
		logic                               dropped;
		logic [ukvt_pkg::ENTRY_COUNT_W-1:0] entry_count;
		logic                               is_empty;
		logic                               is_full;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ukvt_req_if req_if ();
	ukvt_rsp_if rsp_if ();

	unordered_key_value_table_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow of the table contents
	ukvt_pkg::data_t tbl_keys [ukvt_pkg::CAPACITY];
	ukvt_pkg::data_t tbl_vals [ukvt_pkg::CAPACITY];
	int unsigned     tbl_used = 0;

	table_result_t   pending_results[$];
	ukvt_pkg::data_t key_pool [KEY_POOL_N];
	int unsigned     send_idle_pct = 26;
	int unsigned     recv_idle_pct = 72;
	int unsigned     mismatch_count = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic table_result_t predict_table_op(ukvt_pkg::action_t op,
		ukvt_pkg::data_t k, ukvt_pkg::data_t v);
		table_result_t res;
		int unsigned   slot;
		logic          hit;
		slot = tbl_used;
		for (int unsigned i = 0; i < tbl_used; i++) begin
			if (tbl_keys[i] == k && slot == tbl_used)
				slot = i;
		end
		hit = (slot < tbl_used);
		res.read_value = ukvt_pkg::MISS_MARK;
		res.found = hit;
		res.dropped = 1'b0;
		case (op)
			ukvt_pkg::ACT_LOOKUP: begin
				if (hit)
					res.read_value = tbl_vals[slot];
			end
			ukvt_pkg::ACT_INSERT: begin
				if (!hit) begin
					if (tbl_used >= ukvt_pkg::CAPACITY) begin
						res.dropped = 1'b1;
					end else begin
						tbl_keys[tbl_used] = k;
						tbl_vals[tbl_used] = v;
						tbl_used++;
					end
				end
			end
			ukvt_pkg::ACT_DELETE: begin
				if (hit) begin
					for (int unsigned i = slot; i + 1 < tbl_used; i++) begin
						tbl_keys[i] = tbl_keys[i + 1];
						tbl_vals[i] = tbl_vals[i + 1];
					end
					tbl_used--;
				end
			end
			default: ;
		endcase
		res.entry_count = tbl_used[ukvt_pkg::ENTRY_COUNT_W-1:0];
		res.is_empty = (tbl_used == 0);
		res.is_full = (tbl_used == ukvt_pkg::CAPACITY);
		return res;
	endfunction

	task automatic report_mismatch(string field, logic signed [REPORT_W-1:0] expd,
		logic signed [REPORT_W-1:0] got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expd, got);
	endtask

	// handshake values are stable from the falling edge to the next rising edge
	always @(negedge clk) begin
		table_result_t got;
		table_result_t expd;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.read_value = rsp_if.read_value;
			got.found = rsp_if.found;
			got.dropped = rsp_if.dropped;
			got.entry_count = rsp_if.entry_count;
			got.is_empty = rsp_if.is_empty;
			got.is_full = rsp_if.is_full;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected, read_value %0d count %0d",
					$time, got.read_value, got.entry_count);
			end else begin
				expd = pending_results.pop_front();
				if (got.read_value !== expd.read_value)
					report_mismatch("read_value", REPORT_W'(expd.read_value),
						REPORT_W'(got.read_value));
				if (got.found !== expd.found)
					report_mismatch("found", REPORT_W'(expd.found), REPORT_W'(got.found));
				if (got.dropped !== expd.dropped)
					report_mismatch("dropped", REPORT_W'(expd.dropped),
						REPORT_W'(got.dropped));
				if (got.entry_count !== expd.entry_count)
					report_mismatch("entry_count", REPORT_W'(expd.entry_count),
						REPORT_W'(got.entry_count));
				if (got.is_empty !== expd.is_empty)
					report_mismatch("is_empty", REPORT_W'(expd.is_empty),
						REPORT_W'(got.is_empty));
				if (got.is_full !== expd.is_full)
					report_mismatch("is_full", REPORT_W'(expd.is_full),
						REPORT_W'(got.is_full));
			end
		end
	end

	// valid stays high after an item; whoever pauses next lowers it
	task automatic send_op(ukvt_pkg::action_t op, ukvt_pkg::data_t k, ukvt_pkg::data_t v);
		if ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= op;
		req_if.key <= k;
		req_if.entry_value <= v;
		@(negedge clk);
		while (!req_if.ready)
			@(negedge clk);
		@(posedge clk);
		pending_results.push_back(predict_table_op(op, k, v));
	endtask

	task automatic wait_results_drained();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic ukvt_pkg::data_t pick_key(bit prefer_present);
		if (prefer_present && tbl_used != 0 && $urandom_range(99) < 70)
			return tbl_keys[$urandom_range(tbl_used - 1)];
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(KEY_POOL_N - 1)];
		return ukvt_pkg::data_t'($urandom);
	endfunction

	function automatic ukvt_pkg::data_t pick_value();
		if ($urandom_range(99) < 5)
			return ukvt_pkg::MISS_MARK;
		return ukvt_pkg::data_t'($urandom);
	endfunction

	task automatic test_empty_table();
		send_op(ukvt_pkg::ACT_LOOKUP, 32'sd0, 32'sd0);
		send_op(ukvt_pkg::ACT_DELETE, 32'sh8000_0000, 32'sd0);
	endtask

	task automatic test_field_extremes();
		send_op(ukvt_pkg::ACT_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
		send_op(ukvt_pkg::ACT_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
		send_op(ukvt_pkg::ACT_INSERT, 32'sd0, 32'sd0);
		send_op(ukvt_pkg::ACT_INSERT, -32'sd1, -32'sd1);
		send_op(ukvt_pkg::ACT_LOOKUP, 32'sh8000_0000, 32'sd0);
		// duplicate key leaves the stored value alone
		send_op(ukvt_pkg::ACT_INSERT, 32'sh8000_0000, 32'sd5);
		send_op(ukvt_pkg::ACT_NONE, 32'sh7fff_ffff, 32'sh5555_5555);
		send_op(ukvt_pkg::ACT_NONE, 32'sd5, 32'shaaaa_aaaa);
	endtask

	task automatic test_capacity_limits();
		for (int i = 0; i < 12; i++)
			send_op(ukvt_pkg::ACT_INSERT, ukvt_pkg::data_t'(100 + i),
				(i == 3) ? ukvt_pkg::MISS_MARK : pick_value());
		send_op(ukvt_pkg::ACT_INSERT, 32'sd200, 32'sd1);
		send_op(ukvt_pkg::ACT_INSERT, 32'sd0, 32'sd2);
		send_op(ukvt_pkg::ACT_DELETE, 32'sd0, 32'sd0);
		send_op(ukvt_pkg::ACT_DELETE, 32'sd12345, 32'sd0);
		send_op(ukvt_pkg::ACT_LOOKUP, 32'sd111, 32'sd0);
	endtask

	// alternates fill-heavy and drain-heavy stretches over a small key pool
	task automatic test_random_traffic(int unsigned n_items, int unsigned s_pct,
		int unsigned r_pct);
		int unsigned roll;
		bit          filling;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < KEY_POOL_N; i++)
			key_pool[i] = ukvt_pkg::data_t'($urandom);
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		filling = 1'b1;
		for (int unsigned n = 0; n < n_items; n++) begin
			if (n % 60 == 0)
				filling = ~filling;
			roll = $urandom_range(99);
			if (roll < 5)
				send_op(ukvt_pkg::ACT_NONE, pick_key(1'b1), pick_value());
			else if (roll < 30)
				send_op(ukvt_pkg::ACT_LOOKUP, pick_key(1'b1), pick_value());
			else if (roll < (filling ? 80 : 45))
				send_op(ukvt_pkg::ACT_INSERT, pick_key(1'b0), pick_value());
			else
				send_op(ukvt_pkg::ACT_DELETE, pick_key(1'b1), pick_value());
		end
	endtask

	task automatic test_pause_until_drained();
		for (int i = 0; i < 10; i++)
			send_op(ukvt_pkg::ACT_INSERT, pick_key(1'b0), pick_value());
		wait_results_drained();
		for (int i = 0; i < 10; i++)
			send_op(ukvt_pkg::ACT_DELETE, pick_key(1'b1), pick_value());
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ukvt_pkg::ACT_LOOKUP;
		req_if.key = '0;
		req_if.entry_value = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_field_extremes();
		test_capacity_limits();
		test_random_traffic(270, 26, 72);
		test_pause_until_drained();
		test_random_traffic(270, 72, 26);
		test_random_traffic(270, 0, 0);
		wait_results_drained();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/ukvt_pkg.sv
sv/ukvt_if.sv
sv/ukvt_cell.sv
sv/unordered_key_value_table_unit.sv
bench/testbench.sv
